@@ rtl/core/slip_frame_encoder_with_ack_top_defines.svh @@
// Assertion macros for the SLIP frame encoder with segment acknowledge.
// Included by the top level; refers to clk and rst_n of the including module.
`ifndef SLIP_FRAME_ENCODER_WITH_ACK_TOP_DEFINES_SVH
`define SLIP_FRAME_ENCODER_WITH_ACK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SFE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfe: implication check failed");
// next-cycle implication
`define SFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfe: next-cycle check failed");
`else
`define SFE_ASSERT_IMP(label, ante, cons)
`define SFE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/sfe_pkg.sv @@
// Shared types and constants for the SLIP frame encoder.
// No dependencies; used by every module of the block.
`default_nettype none
package sfe_pkg;

  localparam logic [7:0] FRAME_END   = 8'hC0;
  localparam logic [7:0] FRAME_ESC   = 8'hDB;
  localparam logic [7:0] ESC_FOR_END = 8'hDC;
  localparam logic [7:0] ESC_FOR_ESC = 8'hDD;

  localparam int unsigned SUM_BYTES  = 4;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned TICK_W     = 17;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [15:0] MAX_PACKAGE_RST = 16'd128;
  localparam logic [15:0] ACK_LIMIT_RST   = 16'd1000;

  localparam int unsigned CMD_FIFO_DEPTH = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_PACKAGE = 2'd0,
    CFG_ACK_LIMIT   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_DATA = 2'd0,
    ACT_END  = 2'd1,
    ACT_RX   = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    NOTE_SENT    = 2'd0,
    NOTE_REFUSED = 2'd1,
    NOTE_DROPPED = 2'd2
  } note_t;

  typedef enum logic [2:0] {
    CMD_BYTE    = 3'd0,
    CMD_ACK_REQ = 3'd1,
    CMD_END     = 3'd2,
    CMD_REFUSE  = 3'd3,
    CMD_DROP    = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic run;
    logic awaiting;
    logic closing;
  } fe_status_t;

  typedef struct packed {
    logic sec_pending;
  } be_status_t;

endpackage
`default_nettype wire

@@ rtl/core/slip_frame_encoder_with_ack_top.sv @@
// Top level of the SLIP frame encoder with segment acknowledge.
// Depends on sfe_pkg, sfe_front, sfe_cmd_fifo, sfe_back and the defines header.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------------
//   cfg     | in  | cfg_we                 | cfg_addr (reg index), cfg_wdata
//   in      | in  | in_tvalid / in_tready  | tdata: data_byte; tuser: action
//   out     | out | out_tvalid / out_tready| tdata: tx_byte; tuser: note; tlast
//
// A data, receive or tick word is taken whenever in_tready is high; the output
// stage sends one serial word per cycle while out_tready is high, so an escaped
// byte occupies it for two words and the command queue absorbs the difference.
// After an end word is taken on an idle encoder, input stays blocked while the
// front-end sequencer queues four checksum bytes and END; longer while the
// queue is full, shorter when a checksum byte raises an ACK request. Reset
// (rst_n, synchronous): clears all but output and queue data, max_package =
// 128, ACK tick limit = 1000. in_tready drops only while the queue is full or
// the closing sequence runs; out_tready low stalls the back end alone.
`default_nettype none
`include "slip_frame_encoder_with_ack_top_defines.svh"
module slip_frame_encoder_with_ack_top #(
  parameter int unsigned CMD_DEPTH = sfe_pkg::CMD_FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [sfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic [1:0]                     in_tuser,   // [1:0] action
  // output words
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] tx_byte
  output logic [1:0]                     out_tuser,  // [1:0] note
  output logic                           out_tlast
);

  logic                cmd_push;
  logic                cmd_full;
  logic                cmd_pop;
  logic                cmd_empty;
  sfe_pkg::cmd_t       push_cmd;
  sfe_pkg::cmd_t       head_cmd;
  sfe_pkg::fe_status_t fe_stat;
  sfe_pkg::be_status_t be_stat;
  sfe_pkg::note_t      out_note;
  logic                note_shown;
  logic                end_on_idle;

  // front: classify words, update checksum/segment/ACK state, queue commands
  sfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (sfe_pkg::action_t'(in_tuser)),
    .in_byte   (in_tdata),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd),
    .status    (fe_stat)
  );

  // decoupling queue
  sfe_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .empty    (cmd_empty)
  );

  // back: escape expansion and registered output
  sfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .head_cmd  (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_note  (out_note),
    .out_last  (out_tlast),
    .status    (be_stat)
  );

  assign out_tuser = out_note;

  // terms for the checks below
  assign note_shown  = out_tvalid && (out_tuser != sfe_pkg::NOTE_SENT);
  assign end_on_idle = in_tvalid && in_tready && (in_tuser == sfe_pkg::ACT_END) &&
                       !fe_stat.awaiting && !fe_stat.closing;

  // the closing sequencer owns the queue port while it runs
  `SFE_ASSERT_IMP(a_run_blocks_input, fe_stat.run, !in_tready)
  // queue is never written while full
  `SFE_ASSERT_IMP(a_no_push_when_full, cmd_push, !cmd_full)
  // refused and dropped words carry a zero byte
  `SFE_ASSERT_IMP(a_note_zero_byte, note_shown, out_tdata == 8'h00)
  // a pending escape continuation always sits behind a shown first half
  `SFE_ASSERT_IMP(a_second_half_shown, be_stat.sec_pending, out_tvalid)
  // an accepted end word on an idle encoder starts the closing sequence
  `SFE_ASSERT_NEXT(a_end_starts_run, end_on_idle, fe_stat.run)

endmodule
`default_nettype wire

@@ rtl/core/sfe_cmd_fifo.sv @@
// Small command queue between front and back of the encoder.
// Depends on sfe_pkg (cmd_t, CMD_FIFO_DEPTH).
`default_nettype none
module sfe_cmd_fifo #(
  parameter int unsigned DEPTH = sfe_pkg::CMD_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sfe_pkg::cmd_t head_cmd,
  output logic          empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sfe_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sfe_front.sv @@
// Front end: accepts words, holds checksum, segment and ACK-wait state, and
// queues one command per cycle while the queue has room. Depends on sfe_pkg.
`default_nettype none
module sfe_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sfe_pkg::action_t               in_action,
  input  logic [7:0]                     in_byte,
  input  logic                           cmd_full,
  output logic                           cmd_push,
  output sfe_pkg::cmd_t                  cmd,
  output sfe_pkg::fe_status_t            status
);
  logic [15:0] max_package_r;
  logic [15:0] ack_limit_r;

  logic [31:0]                 sum_r, sum_nxt;
  logic [15:0]                 seg_r, seg_nxt;
  logic                        awaiting_r, awaiting_nxt;
  logic [sfe_pkg::TICK_W-1:0]  wait_r, wait_nxt;
  logic [7:0]                  held_r, held_nxt;
  logic                        closing_r, closing_nxt;
  logic [sfe_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [31:0]                 latched_r, latched_nxt;
  logic                        run_r, run_nxt;

  logic                        accept;
  logic                        busy;
  logic                        seg_hit;
  logic [7:0]                  lat_byte;
  logic [sfe_pkg::TICK_W-1:0]  tick_inc;

  assign in_ready = !run_r && !cmd_full;
  assign accept   = in_valid && in_ready;
  assign busy     = awaiting_r || closing_r;
  assign seg_hit  = (seg_r == max_package_r);
  assign lat_byte = latched_r[{idx_r[1:0], 3'b000} +: 8];
  assign tick_inc = (wait_r == sfe_pkg::TICK_MAX) ? wait_r : wait_r + 1'b1;

  assign status.run      = run_r;
  assign status.awaiting = awaiting_r;
  assign status.closing  = closing_r;

  always_comb begin
    sum_nxt      = sum_r;
    seg_nxt      = seg_r;
    awaiting_nxt = awaiting_r;
    wait_nxt     = wait_r;
    held_nxt     = held_r;
    closing_nxt  = closing_r;
    idx_nxt      = idx_r;
    latched_nxt  = latched_r;
    run_nxt      = run_r;
    cmd_push     = 1'b0;
    cmd.kind     = sfe_pkg::CMD_BYTE;
    cmd.data     = 8'h00;
    cmd.last     = 1'b0;

    if (accept) begin
      unique case (in_action)
        sfe_pkg::ACT_DATA: begin
          cmd_push = 1'b1;
          cmd.last = 1'b1;
          if (busy) begin
            cmd.kind = sfe_pkg::CMD_REFUSE;
          end else if (seg_hit) begin
            cmd.kind     = sfe_pkg::CMD_ACK_REQ;
            awaiting_nxt = 1'b1;
            wait_nxt     = '0;
            held_nxt     = in_byte;
          end else begin
            cmd.data = in_byte;
            sum_nxt  = sum_r + {24'd0, in_byte};
            seg_nxt  = seg_r + 16'd1;
          end
        end
        sfe_pkg::ACT_END: begin
          if (busy) begin
            cmd_push = 1'b1;
            cmd.kind = sfe_pkg::CMD_REFUSE;
            cmd.last = 1'b1;
          end else begin
            latched_nxt = sum_r;
            closing_nxt = 1'b1;
            idx_nxt     = '0;
            run_nxt     = 1'b1;
          end
        end
        sfe_pkg::ACT_RX: begin
          if (awaiting_r && in_byte == sfe_pkg::ESC_FOR_END) begin
            // ACK: restart the segment and release the held byte
            awaiting_nxt = 1'b0;
            wait_nxt     = '0;
            cmd_push     = 1'b1;
            cmd.data     = held_r;
            cmd.last     = !closing_r;
            sum_nxt      = sum_r + {24'd0, held_r};
            seg_nxt      = 16'd1;
            run_nxt      = closing_r;
          end
        end
        sfe_pkg::ACT_TICK: begin
          if (awaiting_r) begin
            if (tick_inc > {1'b0, ack_limit_r}) begin
              awaiting_nxt = 1'b0;
              wait_nxt     = '0;
              cmd_push     = 1'b1;
              cmd.kind     = sfe_pkg::CMD_DROP;
              cmd.last     = !closing_r;
              run_nxt      = closing_r;
            end else begin
              wait_nxt = tick_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (run_r && !cmd_full) begin
      cmd_push = 1'b1;
      if (!idx_r[sfe_pkg::IDX_W-1]) begin
        // one checksum byte per cycle while the queue has room, little-endian
        idx_nxt = idx_r + 1'b1;
        if (seg_hit) begin
          cmd.kind     = sfe_pkg::CMD_ACK_REQ;
          cmd.last     = 1'b1;
          awaiting_nxt = 1'b1;
          wait_nxt     = '0;
          held_nxt     = lat_byte;
          run_nxt      = 1'b0;
        end else begin
          cmd.data = lat_byte;
          sum_nxt  = sum_r + {24'd0, lat_byte};
          seg_nxt  = seg_r + 16'd1;
        end
      end else begin
        cmd.kind    = sfe_pkg::CMD_END;
        cmd.last    = 1'b1;
        sum_nxt     = '0;
        seg_nxt     = '0;
        closing_nxt = 1'b0;
        idx_nxt     = '0;
        run_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_package_r <= sfe_pkg::MAX_PACKAGE_RST;
      ack_limit_r   <= sfe_pkg::ACK_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sfe_pkg::CFG_MAX_PACKAGE: max_package_r <= cfg_wdata;
        sfe_pkg::CFG_ACK_LIMIT:   ack_limit_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      seg_r      <= '0;
      awaiting_r <= 1'b0;
      wait_r     <= '0;
      held_r     <= '0;
      closing_r  <= 1'b0;
      idx_r      <= '0;
      latched_r  <= '0;
      run_r      <= 1'b0;
    end else begin
      sum_r      <= sum_nxt;
      seg_r      <= seg_nxt;
      awaiting_r <= awaiting_nxt;
      wait_r     <= wait_nxt;
      held_r     <= held_nxt;
      closing_r  <= closing_nxt;
      idx_r      <= idx_nxt;
      latched_r  <= latched_nxt;
      run_r      <= run_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sfe_back.sv @@
// Back end: expands queued commands into serial words (SLIP escaping), one word
// per cycle unless out_ready stalls the registered output. Depends on sfe_pkg.
`default_nettype none
module sfe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  sfe_pkg::cmd_t       head_cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output sfe_pkg::note_t      out_note,
  output logic                out_last,
  output sfe_pkg::be_status_t status
);
  logic           ovalid_r, ovalid_nxt;
  logic [7:0]     obyte_r, obyte_nxt;
  sfe_pkg::note_t onote_r, onote_nxt;
  logic           olast_r, olast_nxt;
  logic           sec_r, sec_nxt;
  logic [7:0]     sec_byte_r, sec_byte_nxt;
  logic           sec_last_r, sec_last_nxt;
  logic           load;

  assign load      = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_note  = onote_r;
  assign out_last  = olast_r;
  assign status.sec_pending = sec_r;

  always_comb begin
    ovalid_nxt   = ovalid_r;
    obyte_nxt    = obyte_r;
    onote_nxt    = onote_r;
    olast_nxt    = olast_r;
    sec_nxt      = sec_r;
    sec_byte_nxt = sec_byte_r;
    sec_last_nxt = sec_last_r;
    cmd_pop      = 1'b0;

    if (load) begin
      if (sec_r) begin
        // second half of an escape pair
        ovalid_nxt = 1'b1;
        obyte_nxt  = sec_byte_r;
        onote_nxt  = sfe_pkg::NOTE_SENT;
        olast_nxt  = sec_last_r;
        sec_nxt    = 1'b0;
      end else if (!cmd_empty) begin
        cmd_pop      = 1'b1;
        ovalid_nxt   = 1'b1;
        onote_nxt    = sfe_pkg::NOTE_SENT;
        olast_nxt    = head_cmd.last;
        sec_last_nxt = head_cmd.last;
        unique case (head_cmd.kind)
          sfe_pkg::CMD_BYTE: begin
            if (head_cmd.data == sfe_pkg::FRAME_END) begin
              obyte_nxt    = sfe_pkg::FRAME_ESC;
              olast_nxt    = 1'b0;
              sec_nxt      = 1'b1;
              sec_byte_nxt = sfe_pkg::ESC_FOR_END;
            end else if (head_cmd.data == sfe_pkg::FRAME_ESC) begin
              obyte_nxt    = sfe_pkg::FRAME_ESC;
              olast_nxt    = 1'b0;
              sec_nxt      = 1'b1;
              sec_byte_nxt = sfe_pkg::ESC_FOR_ESC;
            end else begin
              obyte_nxt = head_cmd.data;
            end
          end
          sfe_pkg::CMD_ACK_REQ: begin
            obyte_nxt    = sfe_pkg::FRAME_ESC;
            olast_nxt    = 1'b0;
            sec_nxt      = 1'b1;
            sec_byte_nxt = sfe_pkg::FRAME_END;
          end
          sfe_pkg::CMD_END: begin
            obyte_nxt = sfe_pkg::FRAME_END;
          end
          sfe_pkg::CMD_REFUSE: begin
            obyte_nxt = 8'h00;
            onote_nxt = sfe_pkg::NOTE_REFUSED;
          end
          sfe_pkg::CMD_DROP: begin
            obyte_nxt = 8'h00;
            onote_nxt = sfe_pkg::NOTE_DROPPED;
          end
          default: begin
            ovalid_nxt = 1'b0;
          end
        endcase
      end else begin
        ovalid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      sec_r    <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      sec_r    <= sec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r    <= obyte_nxt;
    onote_r    <= onote_nxt;
    olast_r    <= olast_nxt;
    sec_byte_r <= sec_byte_nxt;
    sec_last_r <= sec_last_nxt;
  end

endmodule
`default_nettype wire
